FILE: rtl/core/box_average_image_downscale_assert.svh
// Assertion macros for the box average downscaler.
`ifndef BOX_AVERAGE_IMAGE_DOWNSCALE_ASSERT_SVH
`define BOX_AVERAGE_IMAGE_DOWNSCALE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define BAD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the next cycle.
`define BAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/bad_pkg.sv
// Package: widths, types and helpers for the box average downscaler.
`default_nettype none
package bad_pkg;
    localparam int MaxWidth  = 256;
    localparam int MaxHeight = 256;
    localparam int XW = $clog2(MaxWidth);
    localparam int YW = $clog2(MaxHeight);
    localparam int AW = XW + YW;
    localparam int SzW = 9;
    localparam int QDepth = 4;
    localparam int QW = $clog2(QDepth);

    localparam logic [1:0] RegSrcW = 2'd0;
    localparam logic [1:0] RegSrcH = 2'd1;
    localparam logic [1:0] RegDstW = 2'd2;
    localparam logic [1:0] RegDstH = 2'd3;

    localparam logic CmdWrite   = 1'b0;
    localparam logic CmdRequest = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] col;
        logic [7:0] row;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       status;
    } t_out_item;

    // Queue entry: a request classified by the front.
    typedef struct packed {
        logic       outside;
        logic [7:0] col;
        logic [7:0] row;
    } t_req;

    typedef struct packed {
        logic [SzW-1:0] src_w;
        logic [SzW-1:0] src_h;
        logic [SzW-1:0] dst_w;
        logic [SzW-1:0] dst_h;
    } t_sizes;

    function automatic logic [SzW-1:0] clamp_size(input logic [SzW-1:0] v,
                                                  input logic [SzW-1:0] hi);
        logic [SzW-1:0] r;
        r = v;
        if (v == '0) r = SzW'(1);
        else if (v > hi) r = hi;
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/bad_if.sv
// Valid/ready channel interfaces for items, results and configuration.
`default_nettype none
interface bad_in_if;
    logic              valid;
    logic              ready;
    bad_pkg::t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bad_out_if;
    logic               valid;
    logic               ready;
    bad_pkg::t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bad_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [8:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/bad_div.sv
// Iterative restoring divider for one channel sum by the pixel count.
`default_nettype none
module bad_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [24:0] i_num,
    input  wire logic [16:0] i_den,
    output logic             o_busy,
    output logic [7:0]       o_quot
);
    logic [4:0]  r_cnt;
    logic [24:0] r_num;
    logic [25:0] r_rem;
    logic [24:0] r_quot;
    logic [16:0] r_den;
    logic [25:0] w_sh;
    logic [25:0] w_sub;

    assign w_sh  = {r_rem[24:0], r_num[24]};
    assign w_sub = w_sh - {9'd0, r_den};

    // Shift in one numerator bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt  <= 5'd25;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 5'd1;
            r_num <= {r_num[23:0], 1'b0};
            if (!w_sub[25]) begin
                r_rem  <= w_sub;
                r_quot <= {r_quot[23:0], 1'b1};
            end else begin
                r_rem  <= w_sh;
                r_quot <= {r_quot[23:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_quot[7:0];
endmodule
`default_nettype wire

FILE: rtl/core/bad_front.sv
// Front: accept items, store pixel writes, classify and queue requests.
`default_nettype none
module bad_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    bad_in_if.sink             in_ch,
    input  wire bad_pkg::t_sizes i_sizes,
    input  wire logic          i_back_idle,
    output logic               o_wr_en,
    output logic [bad_pkg::AW-1:0] o_wr_addr,
    output logic [23:0]        o_wr_data,
    output logic               o_q_valid,
    output bad_pkg::t_req      o_q_data,
    input  wire logic          i_q_pop,
    output logic               o_empty
);
    bad_pkg::t_req r_q [bad_pkg::QDepth];
    logic [bad_pkg::QW:0]   r_cnt;
    logic [bad_pkg::QW-1:0] r_rd;
    logic [bad_pkg::QW-1:0] r_wr;
    logic                   w_acc;
    logic                   w_push;
    logic [bad_pkg::SzW-1:0] w_tw;
    logic [bad_pkg::SzW-1:0] w_th;

    assign w_tw = bad_pkg::clamp_size(i_sizes.dst_w, 9'd256);
    assign w_th = bad_pkg::clamp_size(i_sizes.dst_h, 9'd256);

    // Hold writes until no request is queued or walking the store;
    // stall requests only when the queue is full.
    assign in_ch.ready = (in_ch.data.command == bad_pkg::CmdWrite) ?
                         ((r_cnt == '0) && i_back_idle) :
                         (r_cnt != (bad_pkg::QW+1)'(bad_pkg::QDepth));
    assign w_acc  = in_ch.valid && in_ch.ready;
    assign w_push = w_acc && (in_ch.data.command == bad_pkg::CmdRequest);

    assign o_wr_en   = w_acc && (in_ch.data.command == bad_pkg::CmdWrite);
    assign o_wr_addr = {in_ch.data.row[bad_pkg::YW-1:0], in_ch.data.col[bad_pkg::XW-1:0]};
    assign o_wr_data = {in_ch.data.red_in, in_ch.data.green_in, in_ch.data.blue_in};

    // Hold request queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= '0;
            r_wr  <= '0;
        end else begin
            if (w_push) begin
                r_q[r_wr].outside <= ({1'b0, in_ch.data.col} >= w_tw) ||
                                     ({1'b0, in_ch.data.row} >= w_th);
                r_q[r_wr].col <= in_ch.data.col;
                r_q[r_wr].row <= in_ch.data.row;
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (bad_pkg::QW+1)'(w_push) - (bad_pkg::QW+1)'(i_q_pop);
        end
    end

    assign o_q_valid = (r_cnt != '0);
    assign o_q_data  = r_q[r_rd];
    assign o_empty   = (r_cnt == '0);
endmodule
`default_nettype wire

FILE: rtl/core/bad_back.sv
// Back: walk the window over the frame store, sum, divide and deliver.
`default_nettype none
`include "box_average_image_downscale_assert.svh"
module bad_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire bad_pkg::t_sizes i_sizes,
    input  wire logic          i_wr_en,
    input  wire logic [bad_pkg::AW-1:0] i_wr_addr,
    input  wire logic [23:0]   i_wr_data,
    input  wire logic          i_q_valid,
    input  wire bad_pkg::t_req i_q_data,
    output logic               o_q_pop,
    output logic               o_idle,
    bad_out_if.source          out_ch
);
    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_WIN, S_WALK, S_DRAIN, S_DIV, S_OUT
    } t_state;

    logic [23:0] r_mem [bad_pkg::MaxWidth*bad_pkg::MaxHeight];
    logic [23:0] r_rdata;

    t_state r_state;
    bad_pkg::t_req r_req;
    logic [8:0]  r_sx, r_sy;
    logic [16:0] r_cx, r_cy;
    logic [bad_pkg::XW-1:0] r_x0, r_x1, r_x;
    logic [bad_pkg::YW-1:0] r_y0, r_y1, r_y;
    logic        r_last;
    logic        r_pend;
    logic [24:0] r_sr, r_sg, r_sb;
    logic [16:0] r_count;
    logic        r_div_go;
    logic        r_ov;
    bad_pkg::t_out_item r_out;

    logic [bad_pkg::SzW-1:0] w_sw, w_sh, w_tw, w_th;
    logic [17:0] w_lo_x, w_hi_x, w_lo_y, w_hi_y;
    logic [bad_pkg::AW-1:0] w_rd_addr;
    logic        w_rd_en;
    logic [2:0]  w_busy;
    logic [7:0]  w_qr, w_qg, w_qb;

    assign w_sw = bad_pkg::clamp_size(i_sizes.src_w, 9'(bad_pkg::MaxWidth));
    assign w_sh = bad_pkg::clamp_size(i_sizes.src_h, 9'(bad_pkg::MaxHeight));
    assign w_tw = bad_pkg::clamp_size(i_sizes.dst_w, 9'd256);
    assign w_th = bad_pkg::clamp_size(i_sizes.dst_h, 9'd256);

    // Frame store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) r_mem[i_wr_addr] <= i_wr_data;
        if (w_rd_en) r_rdata <= r_mem[w_rd_addr];
    end

    assign w_rd_en   = (r_state == S_WALK);
    assign w_rd_addr = {r_y, r_x};

    // Window bounds from the registered center.
    assign w_lo_x = {1'b0, r_cx} - {9'd0, r_sx};
    assign w_hi_x = {1'b0, r_cx} + {9'd0, r_sx};
    assign w_lo_y = {1'b0, r_cy} - {9'd0, r_sy};
    assign w_hi_y = {1'b0, r_cy} + {9'd0, r_sy};

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_idle  = (r_state == S_IDLE) && !r_ov;

    // Per-channel dividers share the start pulse.
    bad_div u_div_r (.i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_sr),
                     .i_den(r_count), .o_busy(w_busy[0]), .o_quot(w_qr));
    bad_div u_div_g (.i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_sg),
                     .i_den(r_count), .o_busy(w_busy[1]), .o_quot(w_qg));
    bad_div u_div_b (.i_clk, .i_rst_n, .i_start(r_div_go), .i_num(r_sb),
                     .i_den(r_count), .o_busy(w_busy[2]), .o_quot(w_qb));

    // Sequence one request; the output register parts the result from the next request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ov     <= 1'b0;
            r_div_go <= 1'b0;
            r_pend   <= 1'b0;
        end else begin
            if (out_ch.ready && r_state != S_OUT) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req <= i_q_data;
                        // Step is zero for a one-pixel target; start the step division.
                        r_sr <= {16'd0, w_sw} - 25'd1;
                        r_sg <= {16'd0, w_sh} - 25'd1;
                        r_sb <= '0;
                        r_count <= (w_tw <= 9'd1) ? 17'd1 : {8'd0, w_tw} - 17'd1;
                        r_cx <= (w_th <= 9'd1) ? 17'd1 : {8'd0, w_th} - 17'd1;
                        r_state <= i_q_data.outside ? S_OUT : S_STEP;
                        r_div_go <= !i_q_data.outside;
                    end else begin
                        r_div_go <= 1'b0;
                    end
                end
                S_STEP: begin
                    // First pass: x step on red unit, y numerator on green unit
                    // uses the same den, so run y separately afterwards.
                    if (!r_div_go && w_busy == 3'b000) begin
                        if (!r_pend) begin
                            r_sx <= (w_tw <= 9'd1) ? 9'd0 : {1'b0, w_qr};
                            r_sr <= r_sg;
                            r_count <= r_cx;
                            r_div_go <= 1'b1;
                            r_pend <= 1'b1;
                        end else begin
                            r_sy <= (w_th <= 9'd1) ? 9'd0 : {1'b0, w_qr};
                            r_pend <= 1'b0;
                            r_div_go <= 1'b0;
                            r_state <= S_WIN;
                        end
                    end else begin
                        r_div_go <= 1'b0;
                    end
                end
                S_WIN: begin
                    // Register the sampled center.
                    r_cx <= 17'(r_req.col * r_sx);
                    r_cy <= 17'(r_req.row * r_sy);
                    r_sr <= '0; r_sg <= '0; r_sb <= '0;
                    r_count <= '0;
                    r_div_go <= 1'b0;
                    r_state <= S_DRAIN;
                    r_pend  <= 1'b1;
                end
                S_DRAIN: begin
                    if (r_pend) begin
                        // Clip window to the source frame.
                        r_x0 <= w_lo_x[17] ? '0 : bad_pkg::XW'(w_lo_x);
                        r_y0 <= w_lo_y[17] ? '0 : bad_pkg::YW'(w_lo_y);
                        r_x  <= w_lo_x[17] ? '0 : bad_pkg::XW'(w_lo_x);
                        r_y  <= w_lo_y[17] ? '0 : bad_pkg::YW'(w_lo_y);
                        r_x1 <= (w_hi_x > {9'd0, w_sw} - 18'd1) ?
                                bad_pkg::XW'(w_sw - 9'd1) : bad_pkg::XW'(w_hi_x);
                        r_y1 <= (w_hi_y > {9'd0, w_sh} - 18'd1) ?
                                bad_pkg::YW'(w_sh - 9'd1) : bad_pkg::YW'(w_hi_y);
                        r_pend <= 1'b0;
                        r_last <= 1'b0;
                        r_div_go <= 1'b0;
                        r_state <= S_WALK;
                    end else begin
                        // Accumulate the last read, then divide.
                        r_sr <= r_sr + 25'(r_rdata[23:16]);
                        r_sg <= r_sg + 25'(r_rdata[15:8]);
                        r_sb <= r_sb + 25'(r_rdata[7:0]);
                        r_count <= r_count + 17'd1;
                        r_div_go <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_WALK: begin
                    // Issue one read per cycle; add the previous one.
                    if (r_last) begin
                        r_sr <= r_sr + 25'(r_rdata[23:16]);
                        r_sg <= r_sg + 25'(r_rdata[15:8]);
                        r_sb <= r_sb + 25'(r_rdata[7:0]);
                        r_count <= r_count + 17'd1;
                    end
                    r_last <= 1'b1;
                    r_div_go <= 1'b0;
                    if (r_x == r_x1) begin
                        r_x <= r_x0;
                        if (r_y == r_y1) r_state <= S_DRAIN;
                        else r_y <= r_y + 1'b1;
                    end else begin
                        r_x <= r_x + 1'b1;
                    end
                end
                S_DIV: begin
                    r_div_go <= 1'b0;
                    if (!r_div_go && w_busy == 3'b000) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_div_go <= 1'b0;
                    if (!r_ov || out_ch.ready) begin
                        r_ov <= 1'b1;
                        r_out.status <= r_req.outside;
                        r_out.red_out   <= r_req.outside ? 8'd0 : w_qr;
                        r_out.green_out <= r_req.outside ? 8'd0 : w_qg;
                        r_out.blue_out  <= r_req.outside ? 8'd0 : w_qb;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_div_go <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    `BAD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, r_ov && !out_ch.ready, r_ov,
                     "result dropped while stalled")
    `BAD_ASSERT_IMP(a_pop_idle, i_clk, i_rst_n, o_q_pop, r_state == S_IDLE,
                    "queue popped while busy")
    `BAD_ASSERT_IMP(a_div_quiet, i_clk, i_rst_n, r_div_go, w_busy == 3'b000,
                    "divider restarted while busy")
    `BAD_ASSERT_IMP(a_walk_bounds, i_clk, i_rst_n, r_state == S_WALK,
                    r_x <= r_x1 && r_y <= r_y1, "window walk out of bounds")
endmodule
`default_nettype wire

FILE: rtl/core/box_average_image_downscale.sv
// Top level: box average downscaler with decoupled front and back.
// Sequence: a write is registered into the store; a request is popped, runs the x and y step
// divisions, the window walk with one read per window pixel, the averaging division and output.
// Throughput: one write per cycle while no request is queued or in progress; requests one at
// a time, bounded by the window walk over the single store read port and the serial dividers.
// Reset: synchronous active low; sizes return to 256, 256, 128, 128; the store is not cleared.
`default_nettype none
module box_average_image_downscale (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bad_in_if.sink    in_ch,
    bad_cfg_if.sink   cfg_ch,
    bad_out_if.source out_ch
);
    bad_pkg::t_sizes r_sizes;
    bad_pkg::t_req   w_q_data;
    logic w_wr_en, w_q_valid, w_q_pop, w_empty, w_idle;
    logic [bad_pkg::AW-1:0] w_wr_addr;
    logic [23:0] w_wr_data;

    // Accept size writes only while no request is queued or in progress.
    assign cfg_ch.ready = w_empty && w_idle;

    // Hold size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes.src_w <= 9'd256;
            r_sizes.src_h <= 9'd256;
            r_sizes.dst_w <= 9'd128;
            r_sizes.dst_h <= 9'd128;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.index)
                bad_pkg::RegSrcW: r_sizes.src_w <= cfg_ch.wdata;
                bad_pkg::RegSrcH: r_sizes.src_h <= cfg_ch.wdata;
                bad_pkg::RegDstW: r_sizes.dst_w <= cfg_ch.wdata;
                bad_pkg::RegDstH: r_sizes.dst_h <= cfg_ch.wdata;
                default: ;
            endcase
        end
    end

    bad_front u_front (
        .i_clk, .i_rst_n, .in_ch, .i_sizes(r_sizes), .i_back_idle(w_idle),
        .o_wr_en(w_wr_en), .o_wr_addr(w_wr_addr), .o_wr_data(w_wr_data),
        .o_q_valid(w_q_valid), .o_q_data(w_q_data), .i_q_pop(w_q_pop),
        .o_empty(w_empty)
    );

    bad_back u_back (
        .i_clk, .i_rst_n, .i_sizes(r_sizes),
        .i_wr_en(w_wr_en), .i_wr_addr(w_wr_addr), .i_wr_data(w_wr_data),
        .i_q_valid(w_q_valid), .i_q_data(w_q_data), .o_q_pop(w_q_pop),
        .o_idle(w_idle), .out_ch
    );
endmodule
`default_nettype wire
